[sv/assert_macros.svh]
// Assertion macros for the inverse-depth filter RTL.
// No dependencies; included by idgf_ctrl, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[sv/idgf_pkg.sv]
// Types and constants for the inverse-depth gated fusion filter.
// No dependencies; used by the controller, datapath, divider and top level.
`default_nettype none

package idgf_pkg;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [VAL_W-1:0]   VAR_ONE     = 32'h0100_0000;
  localparam logic [VAL_W-1:0]   VAR_FLOOR   = 32'd16777;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd6144;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_GATE_MUL,
    ST_GATE_CMP,
    ST_GROW_MUL,
    ST_GROW_WR,
    ST_STEP_MUL,
    ST_STEP_LD,
    ST_STEP_RUN,
    ST_VAR_MUL,
    ST_VAR_LD,
    ST_VAR_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_GATE,
    MUL_GROW,
    MUL_STEP,
    MUL_VAR
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     prep;
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     gate_wr;
    logic     floor_wr;
    logic     div_start;
    logic     mean_wr;
    logic     var_wr;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic reject;
    logic sum_zero;
    logic div_busy;
  } status_t;

endpackage

`default_nettype wire

[sv/idgf_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on idgf_pkg. Caller guarantees quotient < 2^32 and nonzero divisor.
`default_nettype none

module idgf_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [2*idgf_pkg::VAL_W:0]    num,
  input  wire logic [idgf_pkg::VAL_W:0]      den,
  output logic                               busy,
  output logic [idgf_pkg::VAL_W-1:0]         quo
);

  logic                             busy_r;
  logic [idgf_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [idgf_pkg::VAL_W:0]         rem_r;
  logic [idgf_pkg::VAL_W:0]         den_r;
  logic [idgf_pkg::VAL_W-1:0]       lo_r;
  logic [idgf_pkg::VAL_W-1:0]       q_r;
  logic [idgf_pkg::VAL_W+1:0]       rem_sh;
  logic [idgf_pkg::VAL_W+1:0]       rem_sub;
  logic                             fits;

  always_comb begin
    rem_sh  = {rem_r, lo_r[idgf_pkg::VAL_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    fits    = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= idgf_pkg::DIV_CNT_W'(idgf_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[2*idgf_pkg::VAL_W:idgf_pkg::VAL_W];
      lo_r  <= num[idgf_pkg::VAL_W-1:0];
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[idgf_pkg::VAL_W:0] : rem_sh[idgf_pkg::VAL_W:0];
      lo_r  <= {lo_r[idgf_pkg::VAL_W-2:0], 1'b0};
      q_r   <= {q_r[idgf_pkg::VAL_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

[sv/idgf_dp.sv]
// Datapath: filter state, shared 32x32 multiplier, divider, output register.
// Depends on idgf_pkg and idgf_div; driven by idgf_ctrl commands.
`default_nettype none

module idgf_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire idgf_pkg::cmd_t                 cmd,
  output idgf_pkg::status_t                   status,
  input  wire logic                           cfg_we,
  input  wire logic [idgf_pkg::RATIO_W-1:0]   cfg_wdata,
  input  wire logic                           in_mode,
  input  wire logic [idgf_pkg::VAL_W-1:0]     in_obs,
  input  wire logic [idgf_pkg::VAL_W-1:0]     in_ovar,
  output logic [1:0]                          out_flags,
  output logic [2*idgf_pkg::VAL_W-1:0]        out_data
);

  logic [idgf_pkg::RATIO_W-1:0]   ratio_r;
  logic [idgf_pkg::VAL_W-1:0]     mean_r;
  logic [idgf_pkg::VAL_W-1:0]     var_r;
  logic [idgf_pkg::CNT_W-1:0]     good_r;
  logic [idgf_pkg::CNT_W-1:0]     bad_r;
  logic                           lost_r;
  logic                           acc_r;

  logic                           mode_r;
  logic [idgf_pkg::VAL_W-1:0]     obs_r;
  logic [idgf_pkg::VAL_W-1:0]     ovar_r;
  logic [idgf_pkg::VAL_W-1:0]     diff_r;
  logic [idgf_pkg::VAL_W:0]       sum_r;
  logic                           ge_r;
  logic [2*idgf_pkg::VAL_W-1:0]   prod_r;
  logic [1:0]                     flags_r;
  logic [2*idgf_pkg::VAL_W-1:0]   data_r;

  logic [idgf_pkg::VAL_W-1:0]     mul_a;
  logic [idgf_pkg::VAL_W-1:0]     mul_b;
  logic [2*idgf_pkg::VAL_W-1:0]   gate_lim;
  logic [35:0]                    grown;
  logic [idgf_pkg::CNT_W-1:0]     bad_inc;
  logic [idgf_pkg::CNT_W-1:0]     good_inc;
  logic [2*idgf_pkg::VAL_W:0]     div_num;
  logic                           div_busy;
  logic [idgf_pkg::VAL_W-1:0]     div_q;

  always_comb begin
    case (cmd.mul_sel)
      idgf_pkg::MUL_GATE: begin
        mul_a = diff_r;
        mul_b = diff_r;
      end
      idgf_pkg::MUL_GROW: begin
        mul_a = var_r;
        mul_b = {{(idgf_pkg::VAL_W-idgf_pkg::RATIO_W){1'b0}}, ratio_r};
      end
      idgf_pkg::MUL_STEP: begin
        mul_a = diff_r;
        mul_b = var_r;
      end
      idgf_pkg::MUL_VAR: begin
        mul_a = var_r;
        mul_b = ovar_r;
      end
      default: begin
        mul_a = diff_r;
        mul_b = diff_r;
      end
    endcase
    gate_lim = {6'b0, var_r, 26'b0};
    grown    = prod_r[47:12];
    bad_inc  = (bad_r == '1) ? bad_r : bad_r + 1'b1;
    good_inc = (good_r == '1) ? good_r : good_r + 1'b1;
    div_num  = {1'b0, prod_r} + {{(idgf_pkg::VAL_W+1){1'b0}}, sum_r[idgf_pkg::VAL_W:1]};
  end

  idgf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (sum_r),
    .busy  (div_busy),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= idgf_pkg::RATIO_RESET;
      mean_r  <= '0;
      var_r   <= idgf_pkg::VAR_ONE;
      good_r  <= '0;
      bad_r   <= '0;
      lost_r  <= 1'b0;
      acc_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        ratio_r <= cfg_wdata;
      end
      if (cmd.load) begin
        mean_r <= obs_r;
        good_r <= idgf_pkg::CNT_W'(1);
        acc_r  <= 1'b1;
      end
      if (cmd.gate_wr) begin
        var_r  <= (|grown[35:32]) ? '1 : grown[31:0];
        bad_r  <= bad_inc;
        acc_r  <= 1'b0;
        if ({1'b0, bad_inc} > {good_r, 1'b0}) begin
          lost_r <= 1'b1;
        end
      end
      if (cmd.floor_wr) begin
        var_r  <= idgf_pkg::VAR_FLOOR;
        good_r <= good_inc;
        acc_r  <= 1'b1;
      end
      if (cmd.mean_wr) begin
        mean_r <= ge_r ? mean_r + div_q : mean_r - div_q;
      end
      if (cmd.var_wr) begin
        var_r  <= (div_q < idgf_pkg::VAR_FLOOR) ? idgf_pkg::VAR_FLOOR : div_q;
        good_r <= good_inc;
        acc_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      obs_r  <= in_obs;
      ovar_r <= in_ovar;
    end
    if (cmd.prep) begin
      diff_r <= (mean_r > obs_r) ? mean_r - obs_r : obs_r - mean_r;
      sum_r  <= {1'b0, var_r} + {1'b0, ovar_r};
      ge_r   <= obs_r >= mean_r;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.emit) begin
      flags_r <= {lost_r, acc_r};
      data_r  <= {var_r, mean_r};
    end
  end

  always_comb begin
    status.mode     = mode_r;
    status.reject   = prod_r > gate_lim;
    status.sum_zero = sum_r == '0;
    status.div_busy = div_busy;
  end

  assign out_flags = flags_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[sv/idgf_ctrl.sv]
// Controller FSM: sequences load, gate, grow and fusion steps; owns handshakes.
// Depends on idgf_pkg and assert_macros.svh; commands drive idgf_dp.
`default_nettype none

module idgf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire idgf_pkg::status_t    status,
  output idgf_pkg::cmd_t            cmd
);

  idgf_pkg::state_t state_r;
  idgf_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idgf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = idgf_pkg::MUL_GATE;
    in_tready   = 1'b0;
    case (state_r)
      idgf_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = idgf_pkg::ST_PREP;
        end
      end
      idgf_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        if (!status.mode) begin
          cmd.load  = 1'b1;
          state_nxt = idgf_pkg::ST_DONE;
        end else begin
          state_nxt = idgf_pkg::ST_GATE_MUL;
        end
      end
      idgf_pkg::ST_GATE_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = idgf_pkg::MUL_GATE;
        state_nxt   = idgf_pkg::ST_GATE_CMP;
      end
      idgf_pkg::ST_GATE_CMP: begin
        if (status.reject) begin
          state_nxt = idgf_pkg::ST_GROW_MUL;
        end else if (status.sum_zero) begin
          cmd.floor_wr = 1'b1;
          state_nxt    = idgf_pkg::ST_DONE;
        end else begin
          state_nxt = idgf_pkg::ST_STEP_MUL;
        end
      end
      idgf_pkg::ST_GROW_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = idgf_pkg::MUL_GROW;
        state_nxt   = idgf_pkg::ST_GROW_WR;
      end
      idgf_pkg::ST_GROW_WR: begin
        cmd.gate_wr = 1'b1;
        state_nxt   = idgf_pkg::ST_DONE;
      end
      idgf_pkg::ST_STEP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = idgf_pkg::MUL_STEP;
        state_nxt   = idgf_pkg::ST_STEP_LD;
      end
      idgf_pkg::ST_STEP_LD: begin
        cmd.div_start = 1'b1;
        state_nxt     = idgf_pkg::ST_STEP_RUN;
      end
      idgf_pkg::ST_STEP_RUN: begin
        if (!status.div_busy) begin
          cmd.mean_wr = 1'b1;
          state_nxt   = idgf_pkg::ST_VAR_MUL;
        end
      end
      idgf_pkg::ST_VAR_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = idgf_pkg::MUL_VAR;
        state_nxt   = idgf_pkg::ST_VAR_LD;
      end
      idgf_pkg::ST_VAR_LD: begin
        cmd.div_start = 1'b1;
        state_nxt     = idgf_pkg::ST_VAR_RUN;
      end
      idgf_pkg::ST_VAR_RUN: begin
        if (!status.div_busy) begin
          cmd.var_wr = 1'b1;
          state_nxt  = idgf_pkg::ST_DONE;
        end
      end
      idgf_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = idgf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = idgf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

`include "assert_macros.svh"

  `ASSERT_CLK(a_done_fills_empty_slot, clk, rst_n, (state_r == idgf_pkg::ST_DONE && !out_valid_r) |=> out_valid_r, "result not posted from DONE")
  `ASSERT_CLK(a_div_starts, clk, rst_n, cmd.div_start |=> status.div_busy, "divider did not start")
  `ASSERT_CLK(a_held_result, clk, rst_n, (out_valid_r && !out_tready) |=> out_valid_r, "stalled result dropped")
  `ASSERT_NEVER(a_single_update, clk, rst_n, (cmd.load || cmd.floor_wr) && (cmd.gate_wr || cmd.var_wr), "conflicting state writes")

endmodule

`default_nettype wire

[sv/inverse_depth_gated_fusion_top.sv]
// Top level of the per-landmark inverse-depth filter with outlier gate.
// Depends on idgf_pkg, idgf_ctrl, idgf_dp (which holds idgf_div).
//
//  channel | dir | tdata (low bit up)              | tuser (low bit up)
//  in_     | in  | inv_depth[31:0], obs_variance   | mode
//  out_    | out | mean_out[31:0], variance_out    | accepted, out_of_range
//  cfg_    | in  | cfg_wdata = expand_ratio (Q4.12)| -
//
// One item at a time. A load, a gated-out observation and a fused observation
// with zero variance sum run no division; a fused observation runs two 32-step
// radix-2 divisions in the shared divider.
// in_tready is high in idle, from the cycle the result is posted; a stalled
// result waits in the output register while the next item is taken.
// Synchronous active-low reset, no clearing pass.
`default_nettype none

module inverse_depth_gated_fusion_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // inv_depth[31:0], obs_variance[63:32]
  input  wire logic        in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // mean_out[31:0], variance_out[63:32]
  output logic [1:0]       out_tuser,  // accepted[0], out_of_range[1]
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata   // expand_ratio
);

  idgf_pkg::cmd_t    cmd;
  idgf_pkg::status_t status;

  idgf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  idgf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mode   (in_tuser),
    .in_obs    (in_tdata[31:0]),
    .in_ovar   (in_tdata[63:32]),
    .out_flags (out_tuser),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for inverse_depth_gated_fusion_top: directed table, then random
// landmark tracks, checked against an in-bench model of the gated fusion filter.
// Depends on idgf_pkg and the RTL under sv/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_FUSE = 1'b1;
  localparam logic [15:0] RATIO_MIN = 16'd4096;
  localparam logic [15:0] RATIO_MAX = 16'hFFFF;
  localparam logic [15:0] RATIO_PICK = 16'd0;
  localparam int SETTLE_CYCLES = 100;
  localparam int NUM_PROBES = 17;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 167;

  typedef struct packed {
    logic        accepted;
    logic        lost;
    logic [31:0] mean;
    logic [31:0] variance;
  } estimate_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] depth;
    logic [31:0] obs_var;
    logic        typed;
    estimate_t   want;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{MODE_FUSE, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 1'b0, 32'h0000_0000, idgf_pkg::VAR_FLOOR}},
    '{MODE_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 1'b0, 32'hFFFF_FFFF, idgf_pkg::VAR_FLOOR}},
    '{MODE_FUSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{MODE_FUSE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{MODE_FUSE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{MODE_FUSE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{MODE_FUSE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{MODE_FUSE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{MODE_LOAD, 32'h0100_0000, 32'h0000_0000, 1'b0, '0},
    '{MODE_FUSE, 32'h0100_0010, 32'h0000_0000, 1'b0, '0},
    '{MODE_FUSE, 32'h00FF_FFF0, 32'hFFFF_FFFF, 1'b0, '0},
    '{MODE_FUSE, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0},
    '{MODE_LOAD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{MODE_FUSE, 32'h0000_0000, 32'h8000_0000, 1'b0, '0},
    '{MODE_LOAD, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
    '{MODE_FUSE, 32'h8000_0001, 32'h0000_0001, 1'b0, '0},
    '{MODE_FUSE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0}
  };

  localparam logic [15:0] PHASE_RATIO [NUM_PHASES] = '{
    RATIO_MIN, RATIO_MAX, idgf_pkg::RATIO_RESET, RATIO_PICK, 16'd8192, RATIO_MAX, RATIO_MIN,
    RATIO_PICK
  };
  localparam int PHASE_IDLE [4] = '{0, 83, 0, 37};
  localparam int PHASE_STALL [4] = '{0, 0, 83, 37};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;    // inv_depth[31:0], obs_variance[63:32]
  logic        in_tuser = 1'b0;  // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;        // mean_out[31:0], variance_out[63:32]
  logic [1:0]  out_tuser;        // accepted, out_of_range
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;   // expand_ratio

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  estimate_t pending_q [$];

  // filter state as tracked by the bench
  logic [31:0] est_mean = '0;
  logic [31:0] est_variance = idgf_pkg::VAR_ONE;
  logic [15:0] good_cnt = '0;
  logic [15:0] bad_cnt = '0;
  logic        lost = 1'b0;
  logic [15:0] grow_ratio = idgf_pkg::RATIO_RESET;

  inverse_depth_gated_fusion_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic estimate_t track_item(input logic mode, input logic [31:0] obs,
                                           input logic [31:0] obs_var);
    logic [31:0] diff;
    logic [63:0] diff_sq;
    logic [63:0] gate_lim;
    logic [47:0] grown;
    logic [32:0] den;
    logic [64:0] step_q;
    logic [64:0] var_q;
    logic        accepted;
    if (mode == MODE_LOAD) begin
      est_mean = obs;
      good_cnt = 16'd1;
      accepted = 1'b1;
    end else begin
      diff = (est_mean > obs) ? est_mean - obs : obs - est_mean;
      diff_sq = 64'(diff) * 64'(diff);
      gate_lim = 64'(est_variance) << 26;
      if (diff_sq > gate_lim) begin
        grown = (48'(est_variance) * 48'(grow_ratio)) >> 12;
        est_variance = (grown[47:32] != 0) ? 32'hFFFF_FFFF : grown[31:0];
        bad_cnt = (bad_cnt == 16'hFFFF) ? bad_cnt : bad_cnt + 16'd1;
        if (17'(bad_cnt) > (17'(good_cnt) << 1)) lost = 1'b1;
        accepted = 1'b0;
      end else begin
        den = 33'(est_variance) + 33'(obs_var);
        if (den == 0) begin
          est_variance = idgf_pkg::VAR_FLOOR;
        end else begin
          step_q = (65'(diff) * 65'(est_variance) + 65'(den >> 1)) / 65'(den);
          var_q = (65'(est_variance) * 65'(obs_var) + 65'(den >> 1)) / 65'(den);
          est_mean = (obs >= est_mean) ? est_mean + step_q[31:0] : est_mean - step_q[31:0];
          est_variance = (var_q < 65'(idgf_pkg::VAR_FLOOR)) ? idgf_pkg::VAR_FLOOR
                                                              : var_q[31:0];
        end
        good_cnt = (good_cnt == 16'hFFFF) ? good_cnt : good_cnt + 16'd1;
        accepted = 1'b1;
      end
    end
    return '{accepted, lost, est_mean, est_variance};
  endfunction

  task automatic send_item(input logic mode, input logic [31:0] depth,
                           input logic [31:0] obs_var, input logic typed,
                           input estimate_t want);
    estimate_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {obs_var, depth};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = track_item(mode, depth, obs_var);
    pending_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    estimate_t got;
    estimate_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser[0], out_tuser[1], out_tdata[31:0], out_tdata[63:32]};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transfer acc=%0b lost=%0b mean=%h var=%h",
                 $time, got.accepted, got.lost, got.mean, got.variance);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected acc=%0b lost=%0b mean=%h var=%h", $time,
                   want.accepted, want.lost, want.mean, want.variance);
          $display("%0t:          actual   acc=%0b lost=%0b mean=%h var=%h", $time,
                   got.accepted, got.lost, got.mean, got.variance);
          errors++;
        end
      end
    end
  end

  initial begin
    int          m;
    int          k;
    int          pick;
    logic        mode;
    logic [31:0] depth;
    logic [31:0] obs_var;
    logic [31:0] diff;
    logic [32:0] up;
    logic [15:0] ratio;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PROBES[i])
      send_item(PROBES[i].mode, PROBES[i].depth, PROBES[i].obs_var, PROBES[i].typed,
                PROBES[i].want);
    in_tvalid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      ratio = (PHASE_RATIO[p] == RATIO_PICK) ? 16'($urandom_range(65535, 4096))
                                             : PHASE_RATIO[p];
      cfg_wdata <= ratio;
      cfg_we    <= 1'b1;
      @(posedge clk);
      cfg_we     <= 1'b0;
      grow_ratio = ratio;
      idle_pct   = PHASE_IDLE[p % 4];
      stall_pct  = PHASE_STALL[p % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        obs_var = $urandom >> $urandom_range(31);
        if (pick < 8) begin
          mode  = MODE_LOAD;
          depth = $urandom;
        end else if (pick < 80) begin
          // observation near the current estimate, straddling the two-sigma gate
          mode = MODE_FUSE;
          m = 0;
          for (int b = 0; b < 32; b++) if (est_variance[b]) m = b;
          k = (m + 24) / 2 + $urandom_range(2);
          diff = (k >= 32) ? $urandom : ($urandom & ((32'd1 << k) - 32'd1));
          up = 33'(est_mean) + 33'(diff);
          if ($urandom_range(1) == 1)
            depth = up[32] ? 32'hFFFF_FFFF : up[31:0];
          else
            depth = (est_mean >= diff) ? est_mean - diff : 32'd0;
        end else begin
          mode    = MODE_FUSE;
          depth   = $urandom;
          obs_var = $urandom;
        end
        send_item(mode, depth, obs_var, 1'b0, '0);
      end
      in_tvalid <= 1'b0;
    end

    drain();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/idgf_pkg.sv
sv/idgf_div.sv
sv/idgf_dp.sv
sv/idgf_ctrl.sv
sv/inverse_depth_gated_fusion_top.sv
tb/sv/tb.sv
